// ===== rtl/core/cbd_pkg.sv =====
// Shared types, codes and helpers of the chunked body decoder.
package cbd_pkg;

    localparam int LENGTH_BITS_DEF = 32;

    // Decoder phases.
    localparam logic [3:0] PH_LEN     = 4'd0;
    localparam logic [3:0] PH_LEN_LF  = 4'd1;
    localparam logic [3:0] PH_DATA    = 4'd2;
    localparam logic [3:0] PH_DATA_CR = 4'd3;
    localparam logic [3:0] PH_DATA_LF = 4'd4;
    localparam logic [3:0] PH_FIN_CR  = 4'd5;
    localparam logic [3:0] PH_FIN_LF  = 4'd6;
    localparam logic [3:0] PH_DONE    = 4'd7;
    localparam logic [3:0] PH_FAILED  = 4'd8;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    localparam logic [1:0] ST_BUSY   = 2'd0;
    localparam logic [1:0] ST_DONE   = 2'd1;
    localparam logic [1:0] ST_FAILED = 2'd2;

    localparam logic [2:0] FC_NONE      = 3'd0;
    localparam logic [2:0] FC_BAD_LEN   = 3'd1;
    localparam logic [2:0] FC_BAD_CHUNK = 3'd2;
    localparam logic [2:0] FC_BAD_FINAL = 3'd3;
    localparam logic [2:0] FC_OVERFLOW  = 3'd4;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic [1:0] status;
        logic [2:0] fail_cause;
    } t_result;

    // Returns {is_hex, digit value}.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] res;
        res = 5'd0;
        if (c inside {[8'h30:8'h39]}) begin
            res = {1'b1, c[3:0]};
        end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            res = {1'b1, 4'(c[3:0] + 4'd9)};
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/cbd_if.sv =====
// Valid/ready channel interfaces for the decoder input and result streams.
interface cbd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       restart;

    modport source (output valid, output data_byte, output restart, input ready);
    modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

interface cbd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic [1:0] status;
    logic [2:0] fail_cause;

    modport source (output valid, output payload_byte, output payload_valid,
                    output status, output fail_cause, input ready);
    modport sink   (input valid, input payload_byte, input payload_valid,
                    input status, input fail_cause, output ready);
endinterface

// ===== rtl/core/cbd_step.sv =====
// Next-state and result logic for one body byte of the chunked decoder.
module cbd_step import cbd_pkg::*; #(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic [3:0]             i_phase,
    input  logic [LENGTH_BITS-1:0] i_left,
    input  logic                   i_has_digit,
    input  logic [2:0]             i_fail,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_restart,
    output logic [3:0]             o_phase,
    output logic [LENGTH_BITS-1:0] o_left,
    output logic                   o_has_digit,
    output logic [2:0]             o_fail,
    output t_result                o_result
);

    logic [3:0]             phase;
    logic [LENGTH_BITS-1:0] left;
    logic                   has_digit;
    logic [2:0]             fail;
    logic [4:0]             hex;
    logic [LENGTH_BITS-1:0] left_dec;
    logic                   pay;

    assign hex      = hex_digit(i_data_byte);
    assign left_dec = left - LENGTH_BITS'(1);

    always_comb begin
        // A restart request decodes this byte from the reset state.
        phase     = i_restart ? PH_LEN : i_phase;
        left      = i_restart ? '0 : i_left;
        has_digit = i_restart ? 1'b0 : i_has_digit;
        fail      = i_restart ? FC_NONE : i_fail;

        o_phase     = phase;
        o_left      = left;
        o_has_digit = has_digit;
        o_fail      = fail;
        pay         = 1'b0;

        case (phase)
            PH_LEN: begin
                if (i_data_byte == CH_CR) begin
                    if (has_digit) begin
                        o_phase = PH_LEN_LF;
                    end else begin
                        o_phase = PH_FAILED;
                        o_fail  = FC_BAD_LEN;
                    end
                end else if (!hex[4]) begin
                    o_phase = PH_FAILED;
                    o_fail  = FC_BAD_LEN;
                end else if (left[LENGTH_BITS-1 -: 4] != 4'd0) begin
                    o_phase = PH_FAILED;
                    o_fail  = FC_OVERFLOW;
                end else begin
                    o_left      = {left[LENGTH_BITS-5:0], hex[3:0]};
                    o_has_digit = 1'b1;
                end
            end
            PH_LEN_LF: begin
                if (i_data_byte != CH_LF) begin
                    o_phase = PH_FAILED;
                    o_fail  = FC_BAD_LEN;
                end else begin
                    o_has_digit = 1'b0;
                    o_phase     = (left == '0) ? PH_FIN_CR : PH_DATA;
                end
            end
            PH_DATA: begin
                pay    = 1'b1;
                o_left = left_dec;
                if (left_dec == '0) begin
                    o_phase = PH_DATA_CR;
                end
            end
            PH_DATA_CR: begin
                if (i_data_byte == CH_CR) begin
                    o_phase = PH_DATA_LF;
                end else begin
                    o_phase = PH_FAILED;
                    o_fail  = FC_BAD_CHUNK;
                end
            end
            PH_DATA_LF: begin
                if (i_data_byte == CH_LF) begin
                    o_phase = PH_LEN;
                end else begin
                    o_phase = PH_FAILED;
                    o_fail  = FC_BAD_CHUNK;
                end
            end
            PH_FIN_CR: begin
                if (i_data_byte == CH_CR) begin
                    o_phase = PH_FIN_LF;
                end else begin
                    o_phase = PH_FAILED;
                    o_fail  = FC_BAD_FINAL;
                end
            end
            PH_FIN_LF: begin
                if (i_data_byte == CH_LF) begin
                    o_phase = PH_DONE;
                end else begin
                    o_phase = PH_FAILED;
                    o_fail  = FC_BAD_FINAL;
                end
            end
            PH_DONE: begin
            end
            default: begin
                o_phase = PH_FAILED;
            end
        endcase

        o_result.payload_byte  = pay ? i_data_byte : 8'd0;
        o_result.payload_valid = pay;
        o_result.fail_cause    = o_fail;
        if (o_phase == PH_DONE) begin
            o_result.status = ST_DONE;
        end else if (o_phase == PH_FAILED) begin
            o_result.status = ST_FAILED;
        end else begin
            o_result.status = ST_BUSY;
        end
    end

endmodule

// ===== rtl/core/chunked_body_decoder.sv =====
// Top level of the HTTP chunked transfer body decoder.
// Decodes one body byte per clock: every accepted request produces exactly one
// result in the next cycle, carrying the payload byte (when the byte was chunk
// payload), the status and the failure cause. The decoder state and a single
// result register are updated in the accepting cycle, so a new byte is taken
// every cycle as long as the result register is free or is being drained;
// so throughput is one byte per cycle. Set restart on the first byte of a new
// body; after completion or failure bytes are ignored until restart. Lengths
// up to LENGTH_BITS bits are accepted.
module chunked_body_decoder import cbd_pkg::*; #(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cbd_in_if.sink    i_in,
    cbd_out_if.source o_out
);

    logic [3:0]             r_phase;
    logic [LENGTH_BITS-1:0] r_left;
    logic                   r_has_digit;
    logic [2:0]             r_fail;
    t_result                r_out;
    logic                   r_out_valid;

    logic [3:0]             n_phase;
    logic [LENGTH_BITS-1:0] n_left;
    logic                   n_has_digit;
    logic [2:0]             n_fail;
    t_result                n_out;
    logic                   in_acc;

    cbd_step #(.LENGTH_BITS(LENGTH_BITS)) u_step (
        .i_phase     (r_phase),
        .i_left      (r_left),
        .i_has_digit (r_has_digit),
        .i_fail      (r_fail),
        .i_data_byte (i_in.data_byte),
        .i_restart   (i_in.restart),
        .o_phase     (n_phase),
        .o_left      (n_left),
        .o_has_digit (n_has_digit),
        .o_fail      (n_fail),
        .o_result    (n_out)
    );

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_acc     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LEN;
            r_left      <= '0;
            r_has_digit <= 1'b0;
            r_fail      <= FC_NONE;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_phase     <= n_phase;
                r_left      <= n_left;
                r_has_digit <= n_has_digit;
                r_fail      <= n_fail;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.payload_byte  = r_out.payload_byte;
    assign o_out.payload_valid = r_out.payload_valid;
    assign o_out.status        = r_out.status;
    assign o_out.fail_cause    = r_out.fail_cause;

    // Payload is only ever delivered while the body is still in progress.
    a_payload_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.payload_valid |-> o_out.status == ST_BUSY)
        else $error("payload delivered outside an open body");

    // A failure cause is reported exactly when the status says failed.
    a_cause_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ((o_out.fail_cause != FC_NONE) == (o_out.status == ST_FAILED)))
        else $error("fail cause and status disagree");

    // The data phase is never entered or held with no bytes left.
    a_data_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DATA |-> r_left != '0)
        else $error("data phase with zero bytes left");

    // Every accepted request leaves a result waiting in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_out_valid)
        else $error("accepted request produced no result");

endmodule

// ===== dv/chunked_body_decoder_tb.sv =====
// Self-checking testbench of the chunked body decoder with a built-in predictor.
module chunked_body_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cbd_pkg::*;

    localparam int LB          = LENGTH_BITS_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 80;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cbd_in_if  in_ch ();
    cbd_out_if out_ch ();

    chunked_body_decoder uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #10 i_clk = ~i_clk;

    // Predicted decoder state.
    logic [3:0]    dec_phase;
    logic [LB-1:0] dec_left;
    logic          dec_has_digit;
    logic [2:0]    dec_fail;

    t_result       decoded_q[$];
    logic [7:0]    body_bytes[$];

    bit src_idle_on;
    bit sink_idle_on;
    bit hold_request;

    int n_errors;
    int n_sent;
    int n_payload;
    int n_done;
    int n_cause[5];
    int cycle_count;

    // Returns the value of an ASCII hex digit, or -1 for any other byte.
    function automatic int nibble_of(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - 48;
        if (c >= "A" && c <= "F") return int'(c) - 55;
        if (c >= "a" && c <= "f") return int'(c) - 87;
        return -1;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] d, input bit upper);
        if (d < 4'd10) return 8'("0" + d);
        return upper ? 8'("A" + d - 10) : 8'("a" + d - 10);
    endfunction

    function automatic void enter_fail(input logic [2:0] cause);
        dec_phase = PH_FAILED;
        dec_fail  = cause;
        n_cause[cause]++;
    endfunction

    function automatic t_result decode_byte(input logic [7:0] c, input logic rs);
        t_result r;
        int      nib;
        logic    is_pay;
        is_pay = 1'b0;
        if (rs) begin
            dec_phase     = PH_LEN;
            dec_left      = '0;
            dec_has_digit = 1'b0;
            dec_fail      = FC_NONE;
        end
        case (dec_phase)
            PH_LEN: begin
                nib = nibble_of(c);
                if (c == CH_CR) begin
                    if (dec_has_digit) dec_phase = PH_LEN_LF;
                    else enter_fail(FC_BAD_LEN);
                end else if (nib < 0) begin
                    enter_fail(FC_BAD_LEN);
                end else if (dec_left[LB-1 -: 4] != 4'd0) begin
                    enter_fail(FC_OVERFLOW);
                end else begin
                    dec_left      = {dec_left[LB-5:0], 4'(nib)};
                    dec_has_digit = 1'b1;
                end
            end
            PH_LEN_LF: begin
                if (c != CH_LF) begin
                    enter_fail(FC_BAD_LEN);
                end else begin
                    dec_has_digit = 1'b0;
                    dec_phase     = (dec_left == '0) ? PH_FIN_CR : PH_DATA;
                end
            end
            PH_DATA: begin
                is_pay   = 1'b1;
                dec_left = dec_left - 1'b1;
                if (dec_left == '0) dec_phase = PH_DATA_CR;
            end
            PH_DATA_CR: begin
                if (c == CH_CR) dec_phase = PH_DATA_LF;
                else enter_fail(FC_BAD_CHUNK);
            end
            PH_DATA_LF: begin
                if (c == CH_LF) dec_phase = PH_LEN;
                else enter_fail(FC_BAD_CHUNK);
            end
            PH_FIN_CR: begin
                if (c == CH_CR) dec_phase = PH_FIN_LF;
                else enter_fail(FC_BAD_FINAL);
            end
            PH_FIN_LF: begin
                if (c == CH_LF) begin
                    dec_phase = PH_DONE;
                    n_done++;
                end else begin
                    enter_fail(FC_BAD_FINAL);
                end
            end
            PH_DONE, PH_FAILED: begin
            end
            default: dec_phase = PH_FAILED;
        endcase
        if (is_pay) n_payload++;
        r.payload_byte  = is_pay ? c : 8'd0;
        r.payload_valid = is_pay;
        r.status        = (dec_phase == PH_DONE)   ? ST_DONE :
                          (dec_phase == PH_FAILED) ? ST_FAILED : ST_BUSY;
        r.fail_cause    = dec_fail;
        return r;
    endfunction

    // Offers one request until it is taken; with source idling on, may then pause.
    task automatic send_byte(input logic [7:0] b, input logic rs);
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.restart   <= rs;
        do @(posedge i_clk); while (!in_ch.ready);
        decoded_q.push_back(decode_byte(b, rs));
        n_sent++;
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    // Sends the queued body, with restart on its first byte.
    task automatic send_body();
        foreach (body_bytes[i]) send_byte(body_bytes[i], i == 0);
        body_bytes.delete();
    endtask

    // Stops offering requests and waits until every predicted result has come.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) body_bytes.push_back(s[i]);
    endtask

    task automatic push_crlf();
        body_bytes.push_back(CH_CR);
        body_bytes.push_back(CH_LF);
    endtask

    // Writes a length line body in hex, with optional leading zeros and mixed case.
    task automatic push_length(input logic [63:0] value, input int zeros);
        int nd;
        nd = 1;
        while (nd < 16 && (value >> (4 * nd)) != 0) nd++;
        repeat (zeros) body_bytes.push_back("0");
        for (int i = nd - 1; i >= 0; i--)
            body_bytes.push_back(hex_char(value[4*i +: 4], $urandom_range(0, 1)));
    endtask

    function automatic int lead_zeros();
        return ($urandom_range(0, 5) == 0) ? $urandom_range(1, 9) : 0;
    endfunction

    // Bytes that sit near the decision points of the length and terminator parsing.
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 7))
            0: return CH_CR;
            1: return CH_LF;
            2: return " ";
            3: return ";";
            4: return "-";
            5: return "+";
            6: return hex_char(4'($urandom), $urandom_range(0, 1));
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic build_body();
        int len;
        repeat ($urandom_range(0, 4)) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 60) : $urandom_range(1, 10);
            push_length(len, lead_zeros());
            push_crlf();
            repeat (len) body_bytes.push_back(8'($urandom));
            push_crlf();
        end
        push_length(0, lead_zeros());
        push_crlf();
        push_crlf();
        repeat ($urandom_range(0, 2)) body_bytes.push_back(8'($urandom));
    endtask

    task automatic corrupt_body();
        int pos;
        pos = $urandom_range(0, body_bytes.size() - 1);
        case ($urandom_range(0, 3))
            0: body_bytes[pos] = noise_byte();
            1: while (body_bytes.size() > pos + 1) void'(body_bytes.pop_back());
            2: begin
                body_bytes.delete();
                push_length({4'($urandom_range(1, 15)), 32'($urandom)}, lead_zeros());
                push_crlf();
                repeat ($urandom_range(0, 3)) body_bytes.push_back(8'($urandom));
            end
            default: begin
                body_bytes.delete();
                repeat ($urandom_range(1, 6)) body_bytes.push_back(noise_byte());
            end
        endcase
    endtask

    task automatic test_good_body();
        push_text("2");
        push_crlf();
        body_bytes.push_back(8'h00);
        body_bytes.push_back(8'hFF);
        push_crlf();
        push_text("0");
        push_crlf();
        push_crlf();
        push_text("Z");
        send_body();
    endtask

    task automatic test_length_errors();
        body_bytes.push_back(CH_CR);
        send_body();
        push_text("-");
        send_body();
        body_bytes.push_back(CH_LF);
        send_body();
        push_text("1");
        body_bytes.push_back(CH_CR);
        push_text("X");
        send_body();
    endtask

    task automatic test_overflow();
        push_text("100000000");
        send_body();
    endtask

    task automatic test_terminator_errors();
        push_text("1");
        push_crlf();
        push_text("zX");
        send_body();
        push_text("0");
        push_crlf();
        push_text("X");
        send_body();
    endtask

    // The sink holds off while a long chunk streams in; then the sender waits
    // for every result before it finishes the body.
    task automatic test_backpressure();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        hold_request = 1'b1;
        push_text("28");
        push_crlf();
        repeat (40) body_bytes.push_back(8'($urandom));
        send_body();
        wait_drained();
        push_crlf();
        push_text("0");
        push_crlf();
        push_crlf();
        foreach (body_bytes[i]) send_byte(body_bytes[i], 1'b0);
        body_bytes.delete();
        wait_drained();
    endtask

    task automatic test_random_bodies(input int target, input bit idling);
        while (n_sent < target) begin
            src_idle_on  = idling && ($urandom_range(0, 3) != 0);
            sink_idle_on = idling && ($urandom_range(0, 3) != 0);
            build_body();
            if ($urandom_range(0, 9) < 3) corrupt_body();
            send_body();
        end
    endtask

    // Result sink: random short stalls, and one long hold-off on request.
    initial begin
        int gap;
        int hold;
        gap  = 0;
        hold = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold = LONG_HOLD;
            end
            if (hold > 0) begin
                hold--;
                out_ch.ready <= 1'b0;
            end else if (gap > 0) begin
                gap--;
                out_ch.ready <= 1'b0;
            end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
                gap = $urandom_range(1, 7) - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n === 1'b1 && out_ch.valid && out_ch.ready) begin
            if (decoded_q.size() == 0) begin
                $error("result with no request outstanding");
                n_errors++;
            end else begin
                want = decoded_q.pop_front();
                if (out_ch.payload_byte !== want.payload_byte) begin
                    $error("payload_byte expected %0h got %0h",
                           want.payload_byte, out_ch.payload_byte);
                    n_errors++;
                end
                if (out_ch.payload_valid !== want.payload_valid) begin
                    $error("payload_valid expected %0d got %0d",
                           want.payload_valid, out_ch.payload_valid);
                    n_errors++;
                end
                if (out_ch.status !== want.status) begin
                    $error("status expected %0d got %0d", want.status, out_ch.status);
                    n_errors++;
                end
                if (out_ch.fail_cause !== want.fail_cause) begin
                    $error("fail_cause expected %0d got %0d",
                           want.fail_cause, out_ch.fail_cause);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        in_ch.valid     <= 1'b0;
        in_ch.data_byte <= 8'd0;
        in_ch.restart   <= 1'b0;
        i_rst_n         <= 1'b0;
        dec_phase     = PH_LEN;
        dec_left      = '0;
        dec_has_digit = 1'b0;
        dec_fail      = FC_NONE;
        src_idle_on   = 1'b1;
        sink_idle_on  = 1'b1;
        hold_request  = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_good_body();
        test_length_errors();
        test_overflow();
        test_terminator_errors();
        wait_drained();
        test_backpressure();
        test_random_bodies(1200, 1'b1);
        test_random_bodies(1350, 1'b0);

        wait_drained();
        repeat (4) @(posedge i_clk);
        if (decoded_q.size() != 0) begin
            $error("%0d results never arrived", decoded_q.size());
            n_errors++;
        end
        $display("summary: %0d bytes decoded, %0d payload bytes, %0d bodies completed",
                 n_sent, n_payload, n_done);
        $display("summary: errors by cause: length %0d, chunk end %0d, final end %0d, overflow %0d",
                 n_cause[FC_BAD_LEN], n_cause[FC_BAD_CHUNK], n_cause[FC_BAD_FINAL],
                 n_cause[FC_OVERFLOW]);
        if (n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
